/* hdl/merc_pkg.sv */
// Shared types, codes and reset constants for the motor endstop run controller.
package merc_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int SENSE_WIDTH_DEF = 12;

    localparam int FUNC_W   = 2;
    localparam int MV_W     = 12;
    localparam int MS_W     = 16;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DOWN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_LOCKOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_DELAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_GAP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_NEEDED  = 3'd4;

    localparam logic [MS_W-1:0]    LOCKOUT_RST   = 16'd500;
    localparam logic [MS_W-1:0]    DELAY_RST     = 16'd400;
    localparam logic [MV_W-1:0]    THRESHOLD_RST = 12'd100;
    localparam logic [MS_W-1:0]    GAP_RST       = 16'd200;
    localparam logic [COUNT_W-1:0] NEEDED_RST    = 4'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE = 2'd0,
        MODE_UP   = 2'd1,
        MODE_DOWN = 2'd2
    } mode_t;

    // Classified tick as handed from the front part to the back part.
    typedef struct packed {
        logic  cmd;
        mode_t cmd_mode;
        logic  up;
        logic  down;
        logic  over;
    } item_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

endpackage

/* hdl/merc_front.sv */
// Front part: accepts tick requests and classifies command and sense reading.
module merc_front #(
    parameter int SENSE_WIDTH = merc_pkg::SENSE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [merc_pkg::FUNC_W-1:0] func,
    input  logic                       button_up_pressed,
    input  logic                       button_down_pressed,
    input  logic [merc_pkg::MV_W-1:0]   sensed_mv,
    input  logic [merc_pkg::MV_W-1:0]   threshold,
    output logic                       push,
    output merc_pkg::item_t            push_item,
    input  logic                       q_ready
);
    import merc_pkg::*;

    localparam int SENSE_USE = (SENSE_WIDTH < MV_W) ? SENSE_WIDTH : MV_W;

    logic  front_valid_reg;
    logic  front_valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    assign in_stall  = front_valid_reg && !q_ready;
    assign accept    = in_valid && !in_stall;
    assign push      = front_valid_reg && q_ready;
    assign push_item = item_reg;

    always_comb
    begin
        item_next      = item_reg;
        item_next.cmd  = (func != FUNC_NONE);
        item_next.up   = button_up_pressed;
        item_next.down = button_down_pressed;
        item_next.over = (sensed_mv[SENSE_USE-1:0] > threshold[SENSE_USE-1:0]);
        unique case (func)
            FUNC_UP:   item_next.cmd_mode = MODE_UP;
            FUNC_DOWN: item_next.cmd_mode = MODE_DOWN;
            default:   item_next.cmd_mode = MODE_IDLE;
        endcase
    end

    always_comb
    begin
        if (accept)
            front_valid_next = 1'b1;
        else if (push)
            front_valid_next = 1'b0;
        else
            front_valid_next = front_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

/* hdl/merc_queue.sv */
// Short queue of classified requests between the front and back parts.
module merc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  merc_pkg::item_t push_item,
    output logic            q_ready,
    input  logic            pop,
    output logic            q_valid,
    output merc_pkg::item_t pop_item
);
    import merc_pkg::*;

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign q_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_item = slot_reg[rd_ptr_reg];
    assign do_push  = push && q_ready;
    assign do_pop   = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* hdl/merc_back.sv */
// Back part: run state, lockout and endstop counting, and the result register.
module merc_back #(
    parameter int TIMER_WIDTH = merc_pkg::TIMER_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  merc_pkg::item_t               pop_item,
    output logic                          pop,
    input  logic [merc_pkg::MS_W-1:0]     button_lockout,
    input  logic [merc_pkg::MS_W-1:0]     measure_delay,
    input  logic [merc_pkg::MS_W-1:0]     stall_gap,
    input  logic [merc_pkg::COUNT_W-1:0]  count_needed,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [merc_pkg::MODE_W-1:0]   motor_drive,
    output logic                          endstop_hit
);
    import merc_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > MS_W) ? TIMER_WIDTH : MS_W;

    mode_t                  drive_mode_reg;
    mode_t                  drive_mode_next;
    logic [TIMER_WIDTH-1:0] since_cmd_reg;
    logic [TIMER_WIDTH-1:0] since_cmd_next;
    logic [TIMER_WIDTH-1:0] since_over_reg;
    logic [TIMER_WIDTH-1:0] since_over_next;
    logic [COUNT_W-1:0]     over_count_reg;
    logic [COUNT_W-1:0]     over_count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    mode_t                  out_drive_reg;
    logic                   out_hit_reg;
    logic                   hit_next;

    logic [TIMER_WIDTH-1:0] cmd_tick;
    logic [TIMER_WIDTH-1:0] over_tick;
    logic                   btn_open;
    logic                   btn_act;
    logic                   sense_open;
    logic [COUNT_W-1:0]     count_inc;

    assign pop         = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid   = out_valid_reg;
    assign motor_drive = out_drive_reg;
    assign endstop_hit = out_hit_reg;

    always_comb
    begin
        // saturating tick advance
        cmd_tick  = (&since_cmd_reg) ? since_cmd_reg : since_cmd_reg + 1'b1;
        over_tick = (&since_over_reg) ? since_over_reg : since_over_reg + 1'b1;
        count_inc = (&over_count_reg) ? over_count_reg : over_count_reg + 1'b1;

        drive_mode_next = drive_mode_reg;
        since_cmd_next  = cmd_tick;
        since_over_next = over_tick;
        over_count_next = over_count_reg;
        hit_next        = 1'b0;
        btn_act         = 1'b0;

        if (pop_item.cmd)
        begin
            drive_mode_next = pop_item.cmd_mode;
            since_cmd_next  = '0;
        end

        // a remote command leaves the counter at zero, which closes the lockout
        btn_open = !pop_item.cmd && (CMP_W'(cmd_tick) > CMP_W'(button_lockout));
        if (btn_open)
        begin
            if (drive_mode_reg == MODE_IDLE)
            begin
                if (pop_item.up)
                begin
                    drive_mode_next = MODE_UP;
                    btn_act         = 1'b1;
                end
                else if (pop_item.down)
                begin
                    drive_mode_next = MODE_DOWN;
                    btn_act         = 1'b1;
                end
            end
            else if ((drive_mode_reg == MODE_UP && pop_item.down) ||
                     (drive_mode_reg == MODE_DOWN && pop_item.up))
            begin
                drive_mode_next = MODE_IDLE;
                btn_act         = 1'b1;
            end
        end
        if (btn_act)
            since_cmd_next = '0;

        sense_open = !pop_item.cmd && !btn_act && (drive_mode_next != MODE_IDLE) &&
                     (CMP_W'(cmd_tick) > CMP_W'(measure_delay)) && pop_item.over;
        if (sense_open)
        begin
            if (CMP_W'(over_tick) < CMP_W'(stall_gap))
            begin
                over_count_next = count_inc;
                if (count_inc >= count_needed)
                begin
                    drive_mode_next = MODE_IDLE;
                    over_count_next = '0;
                    hit_next        = 1'b1;
                end
            end
            else
            begin
                over_count_next = '0;
            end
            since_over_next = '0;
        end

        if (pop)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_stall)
            out_valid_next = 1'b1;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_mode_reg <= MODE_IDLE;
            since_cmd_reg  <= '0;
            since_over_reg <= '0;
            over_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_drive_reg  <= MODE_IDLE;
            out_hit_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                drive_mode_reg <= drive_mode_next;
                since_cmd_reg  <= since_cmd_next;
                since_over_reg <= since_over_next;
                over_count_reg <= over_count_next;
                out_drive_reg  <= drive_mode_next;
                out_hit_reg    <= hit_next;
            end
        end
    end

    a_hit_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_hit_reg |-> out_drive_reg == MODE_IDLE)
        else $error("endstop hit with motor still driven");

    a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && hit_next |=> over_count_reg == '0)
        else $error("over count not cleared after endstop hit");

    a_out_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_drive_reg == drive_mode_reg)
        else $error("result drive differs from run state");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped request produced no result");

endmodule

/* hdl/motor_endstop_run_controller_core.sv */
// Top level of the motor endstop run controller: config registers and the three parts.
// After its request is accepted, a result is carried through the front register,
// then the queue, then the result register.
// Throughput: one request per cycle while out_stall is low, set by the state update in the back part.
// A two-entry queue lets the front keep taking requests while a result waits.
// Reset (rst_n low, asynchronous) idles the motor, zeroes counters and loads default config.
module motor_endstop_run_controller_core #(
    parameter int TIMER_WIDTH = merc_pkg::TIMER_WIDTH_DEF,
    parameter int SENSE_WIDTH = merc_pkg::SENSE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [merc_pkg::FUNC_W-1:0]    func,
    input  logic                           button_up_pressed,
    input  logic                           button_down_pressed,
    input  logic [merc_pkg::MV_W-1:0]      sensed_mv,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [merc_pkg::MODE_W-1:0]    motor_drive,
    output logic                           endstop_hit,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [merc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [merc_pkg::MS_W-1:0]      cfg_data
);
    import merc_pkg::*;

    logic [MS_W-1:0]    lockout_reg;
    logic [MS_W-1:0]    delay_reg;
    logic [MV_W-1:0]    threshold_reg;
    logic [MS_W-1:0]    gap_reg;
    logic [COUNT_W-1:0] needed_reg;

    logic  push;
    item_t push_item;
    logic  q_ready;
    logic  q_valid;
    logic  pop;
    item_t pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg   <= LOCKOUT_RST;
            delay_reg     <= DELAY_RST;
            threshold_reg <= THRESHOLD_RST;
            gap_reg       <= GAP_RST;
            needed_reg    <= NEEDED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BUTTON_LOCKOUT: lockout_reg   <= cfg_data;
                CFG_MEASURE_DELAY:  delay_reg     <= cfg_data;
                CFG_THRESHOLD:      threshold_reg <= cfg_data[MV_W-1:0];
                CFG_STALL_GAP:      gap_reg       <= cfg_data;
                CFG_COUNT_NEEDED:   needed_reg    <= cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    merc_front #(
        .SENSE_WIDTH(SENSE_WIDTH)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .func                (func),
        .button_up_pressed   (button_up_pressed),
        .button_down_pressed (button_down_pressed),
        .sensed_mv           (sensed_mv),
        .threshold           (threshold_reg),
        .push                (push),
        .push_item           (push_item),
        .q_ready             (q_ready)
    );

    merc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item)
    );

    merc_back #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .pop_item       (pop_item),
        .pop            (pop),
        .button_lockout (lockout_reg),
        .measure_delay  (delay_reg),
        .stall_gap      (gap_reg),
        .count_needed   (needed_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .motor_drive    (motor_drive),
        .endstop_hit    (endstop_hit)
    );

endmodule
